// ===== hdl/arpw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpw_pkg
// Shared types and constants for the ARP binding conflict watch: event codes,
// FSM states, the result record and the search transaction that walks the
// row of binding cells.
// ----------------------------------------------------------------------------
package arpw_pkg;

    // ARP header values that qualify a frame
    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;

    // Sighting counter ceiling
    localparam logic [15:0] SEEN_MAX = 16'hFFFF;

    // Event codes reported per frame
    typedef enum logic [2:0] {
        EV_IGNORED  = 3'd0,
        EV_NEW      = 3'd1,
        EV_FULL     = 3'd2,
        EV_KNOWN    = 3'd3,
        EV_GRAT     = 3'd4,
        EV_CONFLICT = 3'd5
    } arpw_event_t;

    // Top-level control states
    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_RUN
    } arpw_state_t;

    // One result transaction
    typedef struct packed {
        arpw_event_t  ev;
        logic         grat;
        logic [5:0]   idx;
        logic [47:0]  prev_mac;
        logic [15:0]  seen;
        logic         flagged;
    } arpw_result_t;

    // Search transaction handed from cell to cell
    typedef struct packed {
        logic         valid;
        logic         done;
        logic         grat;
        logic [31:0]  ip;
        logic [47:0]  mac;
        arpw_result_t res;
    } arpw_token_t;

endpackage
`default_nettype wire

// ===== hdl/arp_binding_conflict_watch.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arp_binding_conflict_watch
// Watches parsed ARP frames for IP-to-MAC binding changes.
//
// Usage:
//   s_* carries one parsed ARP frame per transaction (valid/ready).
//   m_* returns exactly one result transaction per frame, in order.
//   Frames that are incomplete, not Ethernet or not IPv4 come back as
//   ignored once the output register is free.
//   Other frames launch a search transaction down a row of TABLE_ENTRIES
//   binding cells, one cell per cycle; the result lands in the output
//   register as the transaction leaves the last cell.
//   One frame is in flight at a time, so a new frame is taken only after
//   the previous one has left the cell row or, if ignored, has been loaded
//   into the output register.
//   The input side is ready again while a finished result still waits in
//   the output register. A stalled receiver holds the next frame in the
//   input register until the output register frees up.
//   Reset empties the table (fill count to zero) and clears all handshakes.
// ----------------------------------------------------------------------------
module arp_binding_conflict_watch #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire          aclk,
    input  wire          aresetn,
    // frame input
    input  wire          s_valid,
    output logic         s_ready,
    input  wire          s_frame_complete,
    input  wire  [15:0]  s_hardware_type,
    input  wire  [15:0]  s_protocol_type,
    input  wire  [31:0]  s_sender_ip,
    input  wire  [47:0]  s_sender_mac,
    input  wire  [31:0]  s_target_ip,
    // result output
    output logic         m_valid,
    input  wire          m_ready,
    output logic [2:0]   m_event_res,
    output logic         m_gratuitous,
    output logic [5:0]   m_entry_index,
    output logic [47:0]  m_previous_mac,
    output logic [15:0]  m_seen_count,
    output logic         m_entry_flagged
);
    import arpw_pkg::*;

    localparam int IDXW = $clog2(TABLE_ENTRIES);
    localparam int CNTW = $clog2(TABLE_ENTRIES + 1);

    arpw_state_t state_reg, state_next;

    // Captured frame
    logic         ignore_reg;
    logic         grat_reg;
    logic [31:0]  ip_reg;
    logic [47:0]  mac_reg;

    logic [CNTW-1:0] used_reg, used_next;

    arpw_result_t out_res_reg;
    logic         m_valid_reg, m_valid_next;

    logic         out_free;
    logic         launch;
    logic         load_ignored;
    logic         in_accept;

    arpw_token_t      tok_chain [TABLE_ENTRIES+1];
    logic [CNTW-1:0]  rem_chain [TABLE_ENTRIES+1];
    logic [IDXW-1:0]  pos_chain [TABLE_ENTRIES+1];

    arpw_token_t      exit_tok;

    assign out_free  = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign exit_tok  = tok_chain[TABLE_ENTRIES];

    // Next state and control
    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        launch       = 1'b0;
        load_ignored = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    if (ignore_reg) begin
                        load_ignored = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        launch     = 1'b1;
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (exit_tok.valid) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Input capture
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            ignore_reg <= !s_frame_complete || (s_hardware_type != HW_ETHERNET) ||
                          (s_protocol_type != PROTO_IPV4);
            grat_reg   <= (s_sender_ip == s_target_ip);
            ip_reg     <= s_sender_ip;
            mac_reg    <= s_sender_mac;
        end
    end

    // Search transaction into the first cell; defaults to table full
    always_comb begin
        tok_chain[0].valid        = launch;
        tok_chain[0].done         = 1'b0;
        tok_chain[0].grat         = grat_reg;
        tok_chain[0].ip           = ip_reg;
        tok_chain[0].mac          = mac_reg;
        tok_chain[0].res.ev       = EV_FULL;
        tok_chain[0].res.grat     = grat_reg;
        tok_chain[0].res.idx      = '0;
        tok_chain[0].res.prev_mac = '0;
        tok_chain[0].res.seen     = '0;
        tok_chain[0].res.flagged  = 1'b0;
        rem_chain[0]              = used_reg;
        pos_chain[0]              = '0;
    end

    // Row of binding cells
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        arpw_cell #(
            .IDXW (IDXW),
            .CNTW (CNTW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok_chain[g]),
            .rem_in  (rem_chain[g]),
            .pos_in  (pos_chain[g]),
            .tok_out (tok_chain[g+1]),
            .rem_out (rem_chain[g+1]),
            .pos_out (pos_chain[g+1])
        );
    end

    // Fill count
    always_comb begin
        used_next = used_reg;
        if (exit_tok.valid && (exit_tok.res.ev == EV_NEW)) begin
            used_next = used_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else begin
            used_reg <= used_next;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_ignored || exit_tok.valid) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (load_ignored) begin
            out_res_reg <= '{ev: EV_IGNORED, grat: 1'b0, idx: '0,
                             prev_mac: '0, seen: '0, flagged: 1'b0};
        end else if (exit_tok.valid) begin
            out_res_reg <= exit_tok.res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_res     = out_res_reg.ev;
    assign m_gratuitous    = out_res_reg.grat;
    assign m_entry_index   = out_res_reg.idx;
    assign m_previous_mac  = out_res_reg.prev_mac;
    assign m_seen_count    = out_res_reg.seen;
    assign m_entry_flagged = out_res_reg.flagged;

    // Assertions
    a_exit_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        exit_tok.valid |-> (state_reg == S_RUN))
        else $error("search transaction left the cell row outside a search");

    a_out_empty_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN) |-> !m_valid_reg)
        else $error("output register occupied while a search is running");

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNTW'(TABLE_ENTRIES))
        else $error("fill count exceeds table size");

    a_new_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (exit_tok.valid && (exit_tok.res.ev == EV_NEW)) |->
            (used_reg < CNTW'(TABLE_ENTRIES)))
        else $error("new binding reported with a full table");

    a_exit_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        exit_tok.valid |-> ((rem_chain[TABLE_ENTRIES] == '0) &&
            (pos_chain[TABLE_ENTRIES] == IDXW'(TABLE_ENTRIES))))
        else $error("slot bookkeeping out of step at the end of the row");

endmodule
`default_nettype wire

// ===== hdl/arpw_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpw_cell
// One binding slot. Holds an IP/MAC pair with its sighting count and conflict
// mark; matches, updates or fills the slot as the search transaction passes,
// then forwards the transaction to the next cell through its output register.
// ----------------------------------------------------------------------------
module arpw_cell #(
    parameter int IDXW = 6,
    parameter int CNTW = 7
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire arpw_pkg::arpw_token_t tok_in,
    input  wire [CNTW-1:0]         rem_in,
    input  wire [IDXW-1:0]         pos_in,
    output arpw_pkg::arpw_token_t  tok_out,
    output logic [CNTW-1:0]        rem_out,
    output logic [IDXW-1:0]        pos_out
);
    import arpw_pkg::*;

    // Slot contents, undefined until filled
    logic [31:0]  ip_reg;
    logic [47:0]  mac_reg;
    logic [15:0]  seen_reg;
    logic         mark_reg;

    arpw_token_t      tok_reg, tok_next;
    logic [CNTW-1:0]  rem_reg, rem_next;
    logic [IDXW-1:0]  pos_reg, pos_next;

    logic        live;
    logic        hit;
    logic        fill;
    logic        mac_diff;
    logic [15:0] seen_inc;

    // Match / fill decision; rem_in counts filled slots still ahead
    always_comb begin
        live     = tok_in.valid && !tok_in.done;
        hit      = live && (rem_in != '0) && (tok_in.ip == ip_reg);
        fill     = live && (rem_in == '0);
        mac_diff = (mac_reg != tok_in.mac);
        seen_inc = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + 16'd1;

        tok_next = tok_in;
        rem_next = (rem_in == '0) ? rem_in : rem_in - 1'b1;
        pos_next = pos_in + 1'b1;

        if (hit) begin
            tok_next.done     = 1'b1;
            tok_next.res.idx  = 6'(pos_in);
            tok_next.res.seen = seen_inc;
            if (mac_diff) begin
                tok_next.res.ev       = EV_CONFLICT;
                tok_next.res.prev_mac = mac_reg;
                tok_next.res.flagged  = 1'b1;
            end else begin
                tok_next.res.ev       = tok_in.grat ? EV_GRAT : EV_KNOWN;
                tok_next.res.prev_mac = '0;
                tok_next.res.flagged  = mark_reg;
            end
        end else if (fill) begin
            tok_next.done         = 1'b1;
            tok_next.res.ev       = EV_NEW;
            tok_next.res.idx      = 6'(pos_in);
            tok_next.res.prev_mac = '0;
            tok_next.res.seen     = 16'd1;
            tok_next.res.flagged  = 1'b0;
        end
    end

    // Slot storage
    always_ff @(posedge aclk) begin
        if (hit) begin
            seen_reg <= seen_inc;
            if (mac_diff) begin
                mac_reg  <= tok_in.mac;
                mark_reg <= 1'b1;
            end
        end else if (fill) begin
            ip_reg   <= tok_in.ip;
            mac_reg  <= tok_in.mac;
            seen_reg <= 16'd1;
            mark_reg <= 1'b0;
        end
    end

    // Forward stage to the neighbor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
        rem_reg <= rem_next;
        pos_reg <= pos_next;
    end

    assign tok_out = tok_reg;
    assign rem_out = rem_reg;
    assign pos_out = pos_reg;

endmodule
`default_nettype wire
